/* design/lbsc_pkg.sv */
// shared types, constants and codes for the lcd backplane segment capture block
package lbsc_pkg;

  // fixed field widths of the stream payload
  localparam int LEVEL_W    = 10;
  localparam int COM_FIELDS = 4;
  localparam int SEG_W      = 32;
  localparam int MASK_W     = 4;
  localparam int IN_W       = 2 * COM_FIELDS * LEVEL_W + SEG_W;
  localparam int OUT_W      = 48;
  localparam int CFG_AW     = 4;
  localparam int CFG_DW     = 32;

  // defaults for the top level parameters
  localparam int BACKPLANES_DEF = 4;
  localparam int SEGMENTS_DEF   = 32;
  localparam int LEVEL_BITS_DEF = 10;

  // command carried in the input tuser
  typedef enum logic [0:0] {
    CMD_SAMPLE  = 1'b0,
    CMD_RESTART = 1'b1
  } cmd_e;

  // configuration register indexes (byte address 4 * index)
  typedef enum logic [1:0] {
    REG_LEVEL2_LOW   = 2'd0,
    REG_LEVEL2_HIGH  = 2'd1,
    REG_BACKPLANES   = 2'd2,
    REG_SEGMENTS     = 2'd3
  } reg_idx_e;

  // what one lane finds about its common line
  typedef struct packed {
    logic diff;
    logic zero;
    logic in_win;
  } lane_flags_t;

  // one result transaction
  typedef struct packed {
    logic              all_captured;
    logic [MASK_W-1:0] captured_mask;
    logic              unstable;
    logic [SEG_W-1:0]  latched_row;
    logic [1:0]        latched_backplane;
    logic              latched;
  } result_t;

endpackage

/* design/lbsc_lane.sv */
// per common line compare lane: stability, zero level and level-2 window
module lbsc_lane #(
  parameter int LEVEL_BITS = lbsc_pkg::LEVEL_BITS_DEF
) (
  input  logic [lbsc_pkg::LEVEL_W-1:0] before_i,
  input  logic [lbsc_pkg::LEVEL_W-1:0] after_i,
  input  logic [lbsc_pkg::LEVEL_W-1:0] lvl2_low_i,
  input  logic [lbsc_pkg::LEVEL_W-1:0] lvl2_high_i,
  output lbsc_pkg::lane_flags_t        flags_o
);

  localparam int LvlW = LEVEL_BITS < lbsc_pkg::LEVEL_W ? LEVEL_BITS : lbsc_pkg::LEVEL_W;
  localparam logic [lbsc_pkg::LEVEL_W-1:0] LevelMask =
    lbsc_pkg::LEVEL_W'((64'(1) << LvlW) - 64'(1));

  logic [lbsc_pkg::LEVEL_W-1:0] before_m;
  logic [lbsc_pkg::LEVEL_W-1:0] after_m;

  // levels are compared after masking to the level resolution
  assign before_m = before_i & LevelMask;
  assign after_m  = after_i & LevelMask;

  assign flags_o.diff   = before_m != after_m;
  assign flags_o.zero   = before_m == '0;
  assign flags_o.in_win = (before_m > lvl2_low_i) && (before_m < lvl2_high_i);

endmodule

/* design/lbsc_merge.sv */
// merges lane flags: picks the backplane, masks the row, keeps captured flags
module lbsc_merge #(
  parameter int LANES    = lbsc_pkg::COM_FIELDS,
  parameter int SEGMENTS = lbsc_pkg::SEGMENTS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         accept_i,
  input  logic                         cmd_i,
  input  lbsc_pkg::lane_flags_t        flags_i [LANES],
  input  logic [2:0]                   bp_used_i,
  input  logic [5:0]                   seg_used_i,
  input  logic [lbsc_pkg::SEG_W-1:0]   seg_bits_i,
  output lbsc_pkg::result_t            result_o
);

  localparam int SegLim = SEGMENTS < lbsc_pkg::SEG_W ? SEGMENTS : lbsc_pkg::SEG_W;

  logic [LANES-1:0]          valid_q, valid_d;
  logic [LANES-1:0]          used, ok, diff;
  logic [2:0]                n_bp;
  logic [5:0]                n_seg;
  logic [lbsc_pkg::SEG_W-1:0] seg_mask;
  logic [1:0]                sel;
  logic                      hit, unstable, latched;

  // clamp the counts to their legal ranges
  always_comb begin
    n_bp = bp_used_i;
    if (n_bp == 3'd0) begin
      n_bp = 3'd1;
    end else if (n_bp > 3'(LANES)) begin
      n_bp = 3'(LANES);
    end
    n_seg = seg_used_i;
    if (n_seg == 6'd0) begin
      n_seg = 6'd1;
    end else if (n_seg > 6'(SegLim)) begin
      n_seg = 6'(SegLim);
    end
    for (int j = 0; j < lbsc_pkg::SEG_W; j++) begin
      seg_mask[j] = 6'(j) < n_seg;
    end
  end

  // a backplane matches when it sits at zero and every other used one is at level 2
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      used[i] = 3'(i) < n_bp;
      diff[i] = flags_i[i].diff;
    end
    for (int i = 0; i < LANES; i++) begin
      ok[i] = used[i] && flags_i[i].zero;
      for (int k = 0; k < LANES; k++) begin
        if (k != i && used[k] && !flags_i[k].in_win) begin
          ok[i] = 1'b0;
        end
      end
    end
    sel = '0;
    for (int i = LANES - 1; i >= 0; i--) begin
      if (ok[i]) begin
        sel = 2'(i);
      end
    end
  end

  assign hit      = |ok;
  assign unstable = |(used & diff);

  // result and next captured flags
  always_comb begin
    result_o = '0;
    latched  = 1'b0;
    valid_d  = valid_q;
    if (cmd_i == lbsc_pkg::CMD_RESTART) begin
      valid_d = '0;
    end else begin
      latched                    = !unstable && hit;
      result_o.latched           = latched;
      result_o.unstable          = unstable;
      result_o.latched_backplane = latched ? sel : 2'd0;
      result_o.latched_row       = latched ? (seg_bits_i & seg_mask) : '0;
      for (int i = 0; i < LANES; i++) begin
        valid_d[i] = valid_q[i] | (latched && sel == 2'(i));
      end
    end
    result_o.captured_mask = lbsc_pkg::MASK_W'(valid_d);
    result_o.all_captured  = &(valid_d | ~used);
  end

  // captured flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (accept_i) begin
      valid_q <= valid_d;
    end
  end

  // a restart leaves no backplane captured
  a_restart_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && cmd_i == lbsc_pkg::CMD_RESTART |=> valid_q == '0)
    else $error("captured flags survive a restart");

  // a stored row always shows up in the captured flags
  a_latch_sets_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && latched |=> valid_q[$past(sel)])
    else $error("latched backplane not flagged as captured");

endmodule

/* design/lcd_backplane_segment_capture_top.sv */
// top level: config registers, compare lanes, merge stage and result queue
// a result is registered in the result queue and offered on m_axis from its head
// throughput: one transaction per cycle unless the result queue is full, with
// combinational lane compare and merge; a two-entry result queue keeps
// s_axis_tready high while one result waits on m_axis
// reset: clears captured flags and the result queue, registers to defaults
module lcd_backplane_segment_capture_top #(
  parameter int BACKPLANES = lbsc_pkg::BACKPLANES_DEF,
  parameter int SEGMENTS   = lbsc_pkg::SEGMENTS_DEF,
  parameter int LEVEL_BITS = lbsc_pkg::LEVEL_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // com_before_0..3, com_after_0..3 (10 bits each), segment_bits (32 bits)
  input  logic [lbsc_pkg::IN_W-1:0]     s_axis_tdata,
  // cmd
  input  logic                          s_axis_tuser,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // latched, latched_backplane (2), latched_row (32), unstable,
  // captured_mask (4), all_captured, zero fill (7)
  output logic [lbsc_pkg::OUT_W-1:0]    m_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lbsc_pkg::CFG_AW-1:0]   paddr,
  input  logic [lbsc_pkg::CFG_DW-1:0]   pwdata,
  output logic [lbsc_pkg::CFG_DW-1:0]   prdata,
  output logic                          pready
);

  localparam int Lanes = BACKPLANES < lbsc_pkg::COM_FIELDS ? BACKPLANES : lbsc_pkg::COM_FIELDS;
  localparam int LW    = lbsc_pkg::LEVEL_W;
  localparam int SegLo = 2 * lbsc_pkg::COM_FIELDS * LW;

  logic [LW-1:0]         lvl2_low_q, lvl2_high_q;
  logic [2:0]            bp_used_q;
  logic [5:0]            seg_used_q;
  lbsc_pkg::reg_idx_e    reg_idx;
  logic                  cfg_wr;

  lbsc_pkg::lane_flags_t flags [Lanes];
  lbsc_pkg::result_t     result;
  lbsc_pkg::result_t     slot0_q, slot1_q;
  logic [1:0]            cnt_q;
  logic                  s_acc, m_acc;

  // configuration port
  assign pready  = 1'b1;
  assign reg_idx = lbsc_pkg::reg_idx_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvl2_low_q  <= '0;
      lvl2_high_q <= '0;
      bp_used_q   <= 3'd4;
      seg_used_q  <= 6'd32;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        lbsc_pkg::REG_LEVEL2_LOW:  lvl2_low_q  <= pwdata[LW-1:0];
        lbsc_pkg::REG_LEVEL2_HIGH: lvl2_high_q <= pwdata[LW-1:0];
        lbsc_pkg::REG_BACKPLANES:  bp_used_q   <= pwdata[2:0];
        lbsc_pkg::REG_SEGMENTS:    seg_used_q  <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (reg_idx)
      lbsc_pkg::REG_LEVEL2_LOW:  prdata = 32'(lvl2_low_q);
      lbsc_pkg::REG_LEVEL2_HIGH: prdata = 32'(lvl2_high_q);
      lbsc_pkg::REG_BACKPLANES:  prdata = 32'(bp_used_q);
      lbsc_pkg::REG_SEGMENTS:    prdata = 32'(seg_used_q);
      default:                   prdata = '0;
    endcase
  end

  // one compare lane per common line, BACKPLANES of them up to four
  for (genvar g = 0; g < Lanes; g++) begin : g_lane
    lbsc_lane #(
      .LEVEL_BITS(LEVEL_BITS)
    ) u_lane (
      .before_i   (s_axis_tdata[g*LW +: LW]),
      .after_i    (s_axis_tdata[(lbsc_pkg::COM_FIELDS + g)*LW +: LW]),
      .lvl2_low_i (lvl2_low_q),
      .lvl2_high_i(lvl2_high_q),
      .flags_o    (flags[g])
    );
  end

  assign s_acc = s_axis_tvalid && s_axis_tready;
  assign m_acc = m_axis_tvalid && m_axis_tready;

  lbsc_merge #(
    .LANES   (Lanes),
    .SEGMENTS(SEGMENTS)
  ) u_merge (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (s_acc),
    .cmd_i     (s_axis_tuser),
    .flags_i   (flags),
    .bp_used_i (bp_used_q),
    .seg_used_i(seg_used_q),
    .seg_bits_i(s_axis_tdata[SegLo +: lbsc_pkg::SEG_W]),
    .result_o  (result)
  );

  // two-entry result queue, head in slot0
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_q + 2'(s_acc) - 2'(m_acc);
    end
  end

  always_ff @(posedge clk_i) begin
    if (m_acc) begin
      slot0_q <= (s_acc && cnt_q == 2'd1) ? result : slot1_q;
      if (s_acc && cnt_q == 2'd2) begin
        slot1_q <= result;
      end
    end else if (s_acc) begin
      if (cnt_q == 2'd0) begin
        slot0_q <= result;
      end else begin
        slot1_q <= result;
      end
    end
  end

  assign s_axis_tready = cnt_q != 2'd2;
  assign m_axis_tvalid = cnt_q != 2'd0;
  assign m_axis_tdata  = {7'd0, slot0_q};

  // queue never overfills
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("result queue count out of range");

  // a discarded sample never stores a row
  a_latch_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(slot0_q.latched && slot0_q.unstable))
    else $error("result both latched and unstable");

  // a stored row is reflected in the captured mask of the same result
  a_latch_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && slot0_q.latched |-> slot0_q.captured_mask[slot0_q.latched_backplane])
    else $error("latched backplane missing from captured mask");

  // a full queue only drains after a result leaves
  a_full_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd2 && !m_axis_tready |=> cnt_q == 2'd2)
    else $error("full queue lost an entry without a transaction");

endmodule

/* test/capture_scoreboard_pkg.sv */
// scoreboard class: predicts each capture result and checks the returned ones
package capture_scoreboard_pkg;
  import lbsc_pkg::*;

  class row_capture_scoreboard;
    // mirror of the configuration registers, reset values
    logic [LEVEL_W-1:0] win_low  = '0;
    logic [LEVEL_W-1:0] win_high = '0;
    logic [2:0]         lanes_cfg = 3'd4;
    logic [5:0]         segs_cfg  = 6'd32;
    // one captured flag per backplane
    logic [MASK_W-1:0]  row_captured = '0;
    result_t            expected_results[$];
    int                 errors = 0;

    function void write_reg(reg_idx_e idx, logic [CFG_DW-1:0] val);
      case (idx)
        REG_LEVEL2_LOW:  win_low   = val[LEVEL_W-1:0];
        REG_LEVEL2_HIGH: win_high  = val[LEVEL_W-1:0];
        REG_BACKPLANES:  lanes_cfg = val[2:0];
        REG_SEGMENTS:    segs_cfg  = val[5:0];
        default: ;
      endcase
    endfunction

    // backplane count saturated to 1..4
    function int used_lanes();
      int n;
      n = lanes_cfg;
      if (n < 1) n = 1;
      if (n > COM_FIELDS) n = COM_FIELDS;
      return n;
    endfunction

    // segment count saturated to 1..32, as a bit mask
    function logic [SEG_W-1:0] kept_segments();
      int n;
      n = segs_cfg;
      if (n < 1) n = 1;
      if (n >= SEG_W) return '1;
      return (SEG_W'(1) << n) - SEG_W'(1);
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // work out the result of one accepted snapshot transaction
    function void note_snapshot(cmd_e cmd, logic [IN_W-1:0] data);
      result_t            r;
      logic [LEVEL_W-1:0] lvl_before[COM_FIELDS];
      logic [LEVEL_W-1:0] lvl_after[COM_FIELDS];
      logic               ok;
      int                 n;
      r = '0;
      n = used_lanes();
      if (cmd == CMD_RESTART) begin
        row_captured = '0;
      end else begin
        for (int i = 0; i < COM_FIELDS; i++) begin
          lvl_before[i] = data[i*LEVEL_W +: LEVEL_W];
          lvl_after[i]  = data[(COM_FIELDS+i)*LEVEL_W +: LEVEL_W];
        end
        for (int i = 0; i < n; i++)
          if (lvl_before[i] != lvl_after[i]) r.unstable = 1'b1;
        // first zero lane with every other used lane strictly inside the window
        if (!r.unstable) begin
          for (int i = 0; i < n; i++) begin
            if (!r.latched) begin
              ok = (lvl_before[i] == '0);
              for (int k = 0; k < n; k++)
                if (k != i && !(lvl_before[k] > win_low && lvl_before[k] < win_high))
                  ok = 1'b0;
              if (ok) begin
                r.latched           = 1'b1;
                r.latched_backplane = 2'(i);
                r.latched_row       = data[2*COM_FIELDS*LEVEL_W +: SEG_W] & kept_segments();
                row_captured[i]     = 1'b1;
              end
            end
          end
        end
      end
      r.captured_mask = row_captured;
      r.all_captured  = 1'b1;
      for (int i = 0; i < n; i++)
        if (!row_captured[i]) r.all_captured = 1'b0;
      expected_results.push_back(r);
    endfunction

    function void compare_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      end
    endfunction

    // compare one returned result with the oldest prediction
    function void check_result(result_t got);
      result_t want;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none actual %0h", $time, got);
        return;
      end
      want = expected_results.pop_front();
      compare_field("latched", want.latched, got.latched);
      compare_field("latched_backplane", want.latched_backplane, got.latched_backplane);
      compare_field("latched_row", want.latched_row, got.latched_row);
      compare_field("unstable", want.unstable, got.unstable);
      compare_field("captured_mask", want.captured_mask, got.captured_mask);
      compare_field("all_captured", want.all_captured, got.all_captured);
    endfunction
  endclass

endpackage

/* test/testbench.sv */
// stream testbench for the lcd backplane segment capture block
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import lbsc_pkg::*;
  import capture_scoreboard_pkg::*;

  typedef enum int {
    STIM_GOOD,
    STIM_UNSTABLE,
    STIM_OUT_OF_WINDOW
  } stim_kind_e;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic [IN_W-1:0]     s_axis_tdata;
  logic                s_axis_tuser;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [OUT_W-1:0]    m_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CFG_AW-1:0]   paddr;
  logic [CFG_DW-1:0]   pwdata;
  logic [CFG_DW-1:0]   prdata;
  logic                pready;

  row_capture_scoreboard sb = new;
  int tx_idle_pct = 19;
  int rx_idle_pct = 51;

  // per phase register settings, extremes included
  int ph_low[8]   = '{100, 0,    500, 1022, 0,  300, 1023, 10};
  int ph_high[8]  = '{900, 1023, 502, 1023, 0,  700, 0,    1000};
  int ph_lanes[8] = '{4,   4,    3,   2,    1,  0,   7,    5};
  int ph_segs[8]  = '{32,  1,    17,  0,    63, 31,  33,   8};

  lcd_backplane_segment_capture_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // run limit
  initial begin
    #2000000;
    $display("lcd_backplane_segment_capture_top: mismatch");
    $finish;
  end

  // receiver back-pressure
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      m_axis_tready <= ($urandom_range(99, 0) >= rx_idle_pct);
    end
  end

  // check every result transaction
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(result_t'(m_axis_tdata[$bits(result_t)-1:0]));
  end

  function automatic logic [IN_W-1:0] pack_snapshot(logic [LEVEL_W-1:0] lb[COM_FIELDS],
                                                    logic [LEVEL_W-1:0] la[COM_FIELDS],
                                                    logic [SEG_W-1:0] seg);
    logic [IN_W-1:0] d;
    for (int i = 0; i < COM_FIELDS; i++) begin
      d[i*LEVEL_W +: LEVEL_W]              = lb[i];
      d[(COM_FIELDS+i)*LEVEL_W +: LEVEL_W] = la[i];
    end
    d[2*COM_FIELDS*LEVEL_W +: SEG_W] = seg;
    return d;
  endfunction

  // snapshot whose levels match before and after
  function automatic logic [IN_W-1:0] steady_snapshot(int l0, int l1, int l2, int l3,
                                                      logic [SEG_W-1:0] seg);
    logic [LEVEL_W-1:0] lv[COM_FIELDS];
    lv = '{LEVEL_W'(l0), LEVEL_W'(l1), LEVEL_W'(l2), LEVEL_W'(l3)};
    return pack_snapshot(lv, lv, seg);
  endfunction

  function automatic logic [IN_W-1:0] noise_snapshot();
    return IN_W'({$urandom, $urandom, $urandom, $urandom});
  endfunction

  // a level strictly inside the middle bias window when the window has room
  function automatic logic [LEVEL_W-1:0] level2_value();
    if (int'(sb.win_high) > int'(sb.win_low) + 1)
      return LEVEL_W'($urandom_range(int'(sb.win_high) - 1, int'(sb.win_low) + 1));
    return LEVEL_W'($urandom);
  endfunction

  // well-formed frame for one backplane, optionally broken on one lane
  function automatic logic [IN_W-1:0] frame_snapshot(stim_kind_e kind);
    logic [LEVEL_W-1:0] lb[COM_FIELDS];
    logic [LEVEL_W-1:0] la[COM_FIELDS];
    logic [SEG_W-1:0]   seg;
    int                 n;
    int                 sel;
    int                 j;
    n   = sb.used_lanes();
    sel = $urandom_range(n - 1, 0);
    for (int i = 0; i < COM_FIELDS; i++) begin
      if (i < n) begin
        lb[i] = level2_value();
        la[i] = lb[i];
      end else begin
        lb[i] = LEVEL_W'($urandom);
        la[i] = ($urandom_range(1, 0) == 0) ? lb[i] : LEVEL_W'($urandom);
      end
    end
    lb[sel] = '0;
    la[sel] = '0;
    seg = ($urandom_range(3, 0) == 0) ? '1 : SEG_W'($urandom);
    case (kind)
      STIM_UNSTABLE: begin
        j = $urandom_range(n - 1, 0);
        la[j] = la[j] ^ (LEVEL_W'(1) << $urandom_range(LEVEL_W - 1, 0));
      end
      STIM_OUT_OF_WINDOW: begin
        if (n > 1) begin
          j = (sel + $urandom_range(n - 1, 1)) % n;
          case ($urandom_range(3, 0))
            0:       lb[j] = sb.win_low;
            1:       lb[j] = sb.win_high;
            2:       lb[j] = '0;
            default: lb[j] = LEVEL_W'($urandom);
          endcase
          la[j] = lb[j];
        end else begin
          lb[sel] = LEVEL_W'($urandom_range(2**LEVEL_W - 1, 1));
          la[sel] = lb[sel];
        end
      end
      default: ;
    endcase
    return pack_snapshot(lb, la, seg);
  endfunction

  // offer one snapshot transaction, called and returning at a falling edge
  task automatic send_snapshot(cmd_e cmd, logic [IN_W-1:0] data);
    if ($urandom_range(99, 0) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= data;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_snapshot(cmd, data);
    @(negedge clk_i);
  endtask

  // wait until every predicted result has come back
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  // register write: setup then access phase, then an idle gap with psel low
  task automatic write_reg(reg_idx_e idx, int val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= CFG_DW'(val);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.write_reg(idx, CFG_DW'(val));
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic apply_setting(int p);
    wait_drained();
    write_reg(REG_LEVEL2_LOW, ph_low[p]);
    write_reg(REG_LEVEL2_HIGH, ph_high[p]);
    write_reg(REG_BACKPLANES, ph_lanes[p]);
    write_reg(REG_SEGMENTS, ph_segs[p]);
  endtask

  // random mix: mostly well-formed frames, some broken, noise and restarts
  task automatic random_snapshots(int count);
    int roll;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(99, 0);
      if (roll < 62)      send_snapshot(CMD_SAMPLE, frame_snapshot(STIM_GOOD));
      else if (roll < 74) send_snapshot(CMD_SAMPLE, frame_snapshot(STIM_UNSTABLE));
      else if (roll < 84) send_snapshot(CMD_SAMPLE, frame_snapshot(STIM_OUT_OF_WINDOW));
      else if (roll < 94) send_snapshot(CMD_SAMPLE, noise_snapshot());
      else                send_snapshot(CMD_RESTART, noise_snapshot());
    end
  endtask

  // main sequence
  initial begin
    rst_ni        = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = CMD_SAMPLE;
    s_axis_tvalid = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset window is empty: no capture with four backplanes
    send_snapshot(CMD_SAMPLE, steady_snapshot(0, 512, 512, 512, '1));
    send_snapshot(CMD_RESTART, '0);

    // directed frames with window 100..900, four backplanes, all segments
    apply_setting(0);
    send_snapshot(CMD_SAMPLE, steady_snapshot(0, 500, 500, 500, '1));
    send_snapshot(CMD_SAMPLE, steady_snapshot(101, 0, 899, 101, '0));
    send_snapshot(CMD_SAMPLE, steady_snapshot(500, 500, 0, 100, 32'h1234_5678));
    send_snapshot(CMD_SAMPLE, steady_snapshot(500, 900, 500, 0, 32'h8765_4321));
    send_snapshot(CMD_SAMPLE, steady_snapshot(899, 899, 899, 0, 32'hA5A5_5A5A));
    // two zero lanes block each other
    send_snapshot(CMD_SAMPLE, steady_snapshot(0, 0, 500, 500, '1));
    // level change on one used lane
    send_snapshot(CMD_SAMPLE, pack_snapshot('{10'd500, 10'd500, 10'd0, 10'd500},
                                            '{10'd500, 10'd501, 10'd0, 10'd500}, '1));
    send_snapshot(CMD_SAMPLE, steady_snapshot(1023, 1023, 1023, 1023, '1));
    send_snapshot(CMD_SAMPLE, steady_snapshot(500, 500, 0, 500, 32'hFFFF_0000));
    // recapture of backplane zero
    send_snapshot(CMD_SAMPLE, steady_snapshot(0, 600, 700, 800, 32'h0000_FFFF));
    send_snapshot(CMD_RESTART, noise_snapshot());
    send_snapshot(CMD_SAMPLE, noise_snapshot());
    send_snapshot(CMD_SAMPLE, steady_snapshot(0, 500, 500, 500, 32'h8000_0001));
    send_snapshot(CMD_RESTART, '1);

    // random phases across register settings and idle patterns
    for (int p = 0; p < 8; p++) begin
      if (p == 3) begin
        tx_idle_pct = 51;
        rx_idle_pct = 19;
      end else if (p == 6) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      apply_setting(p);
      random_snapshots(240);
    end

    wait_drained();
    repeat (8) @(negedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("lcd_backplane_segment_capture_top: match");
    end else begin
      $display("lcd_backplane_segment_capture_top: mismatch");
    end
    $finish;
  end

endmodule

/* files.f */
design/lbsc_pkg.sv
design/lbsc_lane.sv
design/lbsc_merge.sv
design/lcd_backplane_segment_capture_top.sv
test/capture_scoreboard_pkg.sv
test/testbench.sv
